// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files, used by pli_engine.
// ASSERT_AT checks a property on the rising clock edge, off during reset.
// ASSERT_NEVER checks that an expression never holds, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== hdl/pli_pkg.sv =====
`timescale 1ns / 1ps
package pli_pkg;
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W    = 4;
    localparam int DATA_W     = 32;
    localparam int DIV_STEPS  = 33;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int PADDR_W    = 3;

    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic REG_POINTS_USED = 1'b0;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_BELOW  = 2'd1,
        ST_ABOVE  = 2'd2,
        ST_SHORT  = 2'd3
    } status_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] sample;
        logic [CNT_W-1:0]         points;
    } eval_req_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        status_t                  status;
    } eval_rsp_t;
endpackage

// ===== hdl/piecewise_linear_interpolator.sv =====
// Load requests are taken every cycle while idle and write the breakpoint table at once.
// An evaluate with a short table goes straight to the result; otherwise segment k (0 to 14)
// is read and its ends compared with the sample, segment by segment, until the sample is
// clamped below or above or lies in k; a zero-width k gives its y0, else multiply, divide, add.
// The next request is taken in the cycle after the result leaves the engine; one adder is shared.
// Reset (aresetn, synchronous, active low) clears control and points_used, not the table.
`timescale 1ns / 1ps
module piecewise_linear_interpolator import pli_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index [3:0], point_x [35:4], point_y [67:36], sample [99:68], zero [103:100]
    input  logic [103:0]         s_tdata,
    // op [0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value [31:0]
    output logic [31:0]          m_tdata,
    // status_code [1:0]
    output logic [1:0]           m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic [CNT_W-1:0]         points_used_reg;
    logic [CNT_W-1:0]         points_eff;
    logic                     s_accept;
    logic                     eng_idle;
    logic                     rsp_ready;
    eval_req_t                req;
    eval_rsp_t                rsp;
    logic [IDX_W-1:0]         rd_addr0, rd_addr1;
    logic signed [DATA_W-1:0] rd_x0, rd_x1, rd_y0, rd_y1;
    logic                     m_tvalid_reg;
    logic [DATA_W-1:0]        m_value_reg;
    status_t                  m_status_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_used_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_POINTS_USED) begin
            points_used_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_POINTS_USED) ? {{(32 - CNT_W){1'b0}}, points_used_reg}
                                                  : '0;

    assign points_eff = (points_used_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                               : points_used_reg;

    assign s_tready   = eng_idle;
    assign s_accept   = s_tvalid && s_tready;
    assign req.start  = s_accept && (s_tuser == OP_EVAL);
    assign req.sample = s_tdata[99:68];
    assign req.points = points_eff;

    pli_table u_table (
        .aclk     (aclk),
        .wr_en    (s_accept && (s_tuser == OP_LOAD)),
        .wr_index (s_tdata[ENTRY_W-1:0]),
        .wr_x     (s_tdata[35:4]),
        .wr_y     (s_tdata[67:36]),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_x0    (rd_x0),
        .rd_x1    (rd_x1),
        .rd_y0    (rd_y0),
        .rd_y1    (rd_y1)
    );

    pli_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .idle      (eng_idle),
        .rsp       (rsp),
        .rsp_ready (rsp_ready),
        .rd_addr0  (rd_addr0),
        .rd_addr1  (rd_addr1),
        .rd_x0     (rd_x0),
        .rd_x1     (rd_x1),
        .rd_y0     (rd_y0),
        .rd_y1     (rd_y1)
    );

    assign rsp_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rsp_ready) begin
            m_tvalid_reg <= rsp.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_ready && rsp.valid) begin
            m_value_reg  <= rsp.value;
            m_status_reg <= rsp.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;
endmodule

// ===== hdl/pli_table.sv =====
`timescale 1ns / 1ps
module pli_table import pli_pkg::*; (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ENTRY_W-1:0]       wr_index,
    input  logic signed [DATA_W-1:0] wr_x,
    input  logic signed [DATA_W-1:0] wr_y,
    input  logic [IDX_W-1:0]         rd_addr0,
    input  logic [IDX_W-1:0]         rd_addr1,
    output logic signed [DATA_W-1:0] rd_x0,
    output logic signed [DATA_W-1:0] rd_x1,
    output logic signed [DATA_W-1:0] rd_y0,
    output logic signed [DATA_W-1:0] rd_y1
);
    logic signed [DATA_W-1:0] mem_x [MAX_POINTS];
    logic signed [DATA_W-1:0] mem_y [MAX_POINTS];
    logic                     wr_ok;

    assign wr_ok = ({1'b0, wr_index} < (ENTRY_W + 1)'(MAX_POINTS));

    always_ff @(posedge aclk) begin
        if (wr_en && wr_ok) begin
            mem_x[IDX_W'(wr_index)] <= wr_x;
            mem_y[IDX_W'(wr_index)] <= wr_y;
        end
    end

    always_ff @(posedge aclk) begin
        rd_x0 <= mem_x[rd_addr0];
        rd_x1 <= mem_x[rd_addr1];
        rd_y0 <= mem_y[rd_addr0];
        rd_y1 <= mem_y[rd_addr1];
    end
endmodule

// ===== hdl/pli_engine.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pli_engine import pli_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  eval_req_t                req,
    output logic                     idle,
    output eval_rsp_t                rsp,
    input  logic                     rsp_ready,
    output logic [IDX_W-1:0]         rd_addr0,
    output logic [IDX_W-1:0]         rd_addr1,
    input  logic signed [DATA_W-1:0] rd_x0,
    input  logic signed [DATA_W-1:0] rd_x1,
    input  logic signed [DATA_W-1:0] rd_y0,
    input  logic signed [DATA_W-1:0] rd_y1
);
    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_READ = 11'b000_0000_0010,
        S_LO   = 11'b000_0000_0100,
        S_HI   = 11'b000_0000_1000,
        S_DEN  = 11'b000_0001_0000,
        S_DY   = 11'b000_0010_0000,
        S_DYN  = 11'b000_0100_0000,
        S_MUL  = 11'b000_1000_0000,
        S_DIV  = 11'b001_0000_0000,
        S_ADD  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] sample_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [IDX_W-1:0]         i_reg;
    logic [DATA_W-1:0]        num_reg;
    logic [DATA_W-1:0]        den_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [DATA_W:0]          low_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic signed [DATA_W-1:0] value_reg;
    status_t                  status_reg;

    logic [DATA_W+1:0]        alu_a, alu_b, alu_sum;
    logic                     alu_sub, alu_neg;
    logic [2*DATA_W-1:0]      prod;
    logic                     last_seg;
    logic                     den_zero;

    // The single adder/subtractor serves compares, differences, division steps
    // and the final offset.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            S_LO: begin
                alu_a = {{2{sample_reg[DATA_W-1]}}, sample_reg};
                alu_b = {{2{rd_x0[DATA_W-1]}}, rd_x0};
            end
            S_HI: begin
                alu_a = {{2{rd_x1[DATA_W-1]}}, rd_x1};
                alu_b = {{2{sample_reg[DATA_W-1]}}, sample_reg};
            end
            S_DEN: begin
                alu_a = {{2{rd_x1[DATA_W-1]}}, rd_x1};
                alu_b = {{2{rd_x0[DATA_W-1]}}, rd_x0};
            end
            S_DY: begin
                alu_a = {{2{rd_y1[DATA_W-1]}}, rd_y1};
                alu_b = {{2{rd_y0[DATA_W-1]}}, rd_y0};
            end
            S_DYN: begin
                alu_a = {{2{rd_y0[DATA_W-1]}}, rd_y0};
                alu_b = {{2{rd_y1[DATA_W-1]}}, rd_y1};
            end
            S_DIV: begin
                alu_a = {1'b0, rem_reg, low_reg[DATA_W]};
                alu_b = {2'b00, den_reg};
            end
            S_ADD: begin
                alu_a   = {{2{rd_y0[DATA_W-1]}}, rd_y0};
                alu_b   = {2'b00, low_reg[DATA_W-1:0]};
                alu_sub = neg_reg;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + (DATA_W + 2)'(alu_sub);
    assign alu_neg  = alu_sum[DATA_W+1];
    assign prod     = {{DATA_W{1'b0}}, num_reg} * {{DATA_W{1'b0}}, mag_reg};
    assign last_seg = (CNT_W'(i_reg) + CNT_W'(2) == n_reg);
    assign den_zero = (den_reg == '0);

    assign rd_addr0 = i_reg;
    assign rd_addr1 = i_reg + IDX_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    state_next = (req.points < CNT_W'(2)) ? S_DONE : S_READ;
                end
            end
            S_READ: state_next = S_LO;
            S_LO: begin
                if (!alu_neg) begin
                    state_next = S_HI;
                end else if (i_reg == '0 || last_seg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_HI: begin
                if (!alu_neg) begin
                    state_next = S_DEN;
                end else begin
                    state_next = last_seg ? S_DONE : S_READ;
                end
            end
            S_DEN: state_next = S_DY;
            S_DY: begin
                if (den_zero) begin
                    state_next = S_DONE;
                end else begin
                    state_next = alu_neg ? S_DYN : S_MUL;
                end
            end
            S_DYN: state_next = S_MUL;
            S_MUL: state_next = S_DIV;
            S_DIV: begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: state_next = S_DONE;
            S_DONE: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                sample_reg <= req.sample;
                n_reg      <= req.points;
                i_reg      <= '0;
                value_reg  <= INT_MAX;
                status_reg <= ST_SHORT;
            end
            S_LO: begin
                num_reg <= alu_sum[DATA_W-1:0];
                if (alu_neg) begin
                    if (i_reg == '0) begin
                        value_reg  <= rd_y0;
                        status_reg <= ST_BELOW;
                    end else if (last_seg) begin
                        value_reg  <= rd_y1;
                        status_reg <= ST_ABOVE;
                    end else begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                end
            end
            S_HI: begin
                if (alu_neg) begin
                    if (last_seg) begin
                        value_reg  <= rd_y1;
                        status_reg <= ST_ABOVE;
                    end else begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                end
            end
            S_DEN: begin
                den_reg <= alu_sum[DATA_W-1:0];
            end
            S_DY: begin
                neg_reg <= alu_neg;
                mag_reg <= alu_sum[DATA_W-1:0];
                if (den_zero) begin
                    value_reg  <= rd_y0;
                    status_reg <= ST_INTERP;
                end
            end
            S_DYN: begin
                mag_reg <= alu_sum[DATA_W-1:0];
            end
            S_MUL: begin
                rem_reg <= {1'b0, prod[2*DATA_W-1:DATA_W+1]};
                low_reg <= prod[DATA_W:0];
                cnt_reg <= '0;
            end
            S_DIV: begin
                if (!alu_neg) begin
                    rem_reg <= alu_sum[DATA_W-1:0];
                end else begin
                    rem_reg <= {rem_reg[DATA_W-2:0], low_reg[DATA_W]};
                end
                low_reg <= {low_reg[DATA_W-1:0], ~alu_neg};
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
            S_ADD: begin
                value_reg  <= alu_sum[DATA_W-1:0];
                status_reg <= ST_INTERP;
            end
            default: begin
                value_reg <= value_reg;
            end
        endcase
    end

    assign idle       = (state_reg == S_IDLE);
    assign rsp.valid  = (state_reg == S_DONE);
    assign rsp.value  = value_reg;
    assign rsp.status = status_reg;

    `ASSERT_AT(a_start_idle, aclk, aresetn,
               req.start |-> (state_reg == S_IDLE), "start while busy")
    `ASSERT_AT(a_div_done, aclk, aresetn,
               (state_reg == S_ADD) |-> ($past(state_reg) == S_DIV
                   && $past(cnt_reg) == DIV_CNT_W'(DIV_STEPS - 1)), "division cut short")
    `ASSERT_AT(a_rsp_hold, aclk, aresetn,
               (rsp.valid && !rsp_ready) |=> (rsp.valid && $stable(rsp.value)
                   && $stable(rsp.status)), "result changed while held")
    `ASSERT_NEVER(a_seg_range, aclk, aresetn,
                  (state_reg == S_LO) && (CNT_W'(i_reg) + CNT_W'(2) > n_reg),
                  "segment index past last point")
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import pli_pkg::*;

    localparam int ITEMS       = 750;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } mapped_t;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_EVAL,
        ROW_EVAL_KNOWN,
        ROW_POINTS
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [3:0]  idx;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] smp;
        logic [31:0] val;
        status_t     st;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // entry_index [3:0], point_x [35:4], point_y [67:36], sample [99:68], zero [103:100]
    logic [103:0]         s_tdata;
    // op [0]
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // value [31:0]
    logic [31:0]          m_tdata;
    // status_code [1:0]
    logic [1:0]           m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    logic signed [DATA_W-1:0] bp_x [MAX_POINTS];
    logic signed [DATA_W-1:0] bp_y [MAX_POINTS];
    logic [4:0]               points_cfg;
    mapped_t                  mapped_q [$];
    mapped_t                  want;
    int                       err_count = 0;
    int                       sent = 0;
    int                       gap_pct = 25;
    int                       stall_pct = 25;
    int                       stall_left = 0;
    int                       stalled_cycles = 0;
    bit                       steady = 1'b0;

    piecewise_linear_interpolator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic mapped_t map_sample(input logic signed [DATA_W-1:0] s);
        mapped_t     r;
        int          n;
        int          i;
        bit          hit;
        longint      sv;
        longint      x1;
        longint      x2;
        longint      y1;
        longint      y2;
        longint      dy;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] res;
        n = (points_cfg > MAX_POINTS) ? MAX_POINTS : points_cfg;
        hit = 1'b0;
        if (n < 2) begin
            r.value = INT_MAX;
            r.status = ST_SHORT;
        end else if (s < bp_x[0]) begin
            r.value = bp_y[0];
            r.status = ST_BELOW;
        end else begin
            r.value = bp_y[n-1];
            r.status = ST_ABOVE;
            for (i = 0; i + 1 < n && !hit; i++) begin
                if (bp_x[i] <= s && bp_x[i+1] >= s) begin
                    hit = 1'b1;
                    sv = s;
                    x1 = bp_x[i];
                    x2 = bp_x[i+1];
                    y1 = bp_y[i];
                    y2 = bp_y[i+1];
                    num = sv - x1;
                    den = x2 - x1;
                    dy = y2 - y1;
                    mag = (dy < 0) ? -dy : dy;
                    if (den == 0) begin
                        res = y1;
                    end else begin
                        q = (num * mag) / den;
                        res = (dy < 0) ? y1 - q : y1 + q;
                    end
                    r.value = res[31:0];
                    r.status = ST_INTERP;
                end
            end
        end
        return r;
    endfunction

    function automatic row_t row(input row_kind_t kind, input logic [3:0] idx,
                                 input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] smp, input logic [31:0] val,
                                 input status_t st);
        row_t t;
        t.kind = kind;
        t.idx = idx;
        t.px = px;
        t.py = py;
        t.smp = smp;
        t.val = val;
        t.st = st;
        return t;
    endfunction

    task automatic push_request(input logic op, input logic [3:0] idx,
                                input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] smp, input bit known,
                                input logic [31:0] kval, input status_t kst);
        mapped_t m;
        @(negedge aclk);
        s_tuser <= op;
        s_tdata <= {4'b0000, smp, py, px, idx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (op == OP_LOAD) begin
            bp_x[idx] = px;
            bp_y[idx] = py;
        end else begin
            if (known) begin
                m.value = kval;
                m.status = kst;
            end else begin
                m = map_sample(smp);
            end
            mapped_q.push_back(m);
        end
        sent++;
    endtask

    task automatic sender_gap();
        int len;
        if (!steady && $urandom_range(0, 99) < gap_pct) begin
            len = $urandom_range(1, 6);
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (len - 1) @(negedge aclk);
        end
    endtask

    // Loads leave no result behind, so settle keeps waiting after the last result to cover the last one.
    task automatic settle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (mapped_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_points(input logic [4:0] v);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * REG_POINTS_USED);
        pwdata <= {27'($urandom), v};
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        points_cfg = v;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (mapped_q.size() == 0) begin
                $error("unexpected result: value %h, status_code %0d", m_tdata, m_tuser);
                err_count++;
            end else begin
                want = mapped_q.pop_front();
                if (m_tdata !== want.value) begin
                    $error("value: expected %h, actual %h", want.value, m_tdata);
                    err_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status_code: expected %0d, actual %0d", want.status, m_tuser);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles == STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        row_t        plan [$];
        longint      cand [MAX_POINTS];
        longint      key;
        longint      span;
        longint      sv;
        logic [63:0] rnd;
        logic [31:0] pyv;
        int          pick;
        int          pts;
        int          used;
        int          shape;
        int          evals;
        int          a;
        int          b;
        int          k;
        int          r;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        points_cfg = '0;

        // For a points row the register value sits in the sample column.
        plan.push_back(row(ROW_EVAL_KNOWN, 4'h0, 32'h0, 32'h0, 32'h0, INT_MAX, ST_SHORT));
        plan.push_back(row(ROW_POINTS, 4'h0, 32'h0, 32'h0, 32'd1, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_EVAL_KNOWN, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'h7FFF_FFFF, INT_MAX, ST_SHORT));
        plan.push_back(row(ROW_LOAD, 4'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                           32'h0, ST_INTERP));
        plan.push_back(row(ROW_LOAD, 4'h1, 32'h0, 32'h8000_0000, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_LOAD, 4'h2, 32'h0, 32'h0001_0000, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_LOAD, 4'h3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                           32'h0, ST_INTERP));
        plan.push_back(row(ROW_POINTS, 4'h0, 32'h0, 32'h0, 32'd4, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_EVAL_KNOWN, 4'h0, 32'h0, 32'h0, 32'h8000_0000,
                           32'h7FFF_FFFF, ST_INTERP));
        plan.push_back(row(ROW_EVAL, 4'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_EVAL, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_LOAD, 4'h0, 32'hFFFF_0000, 32'd5, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_LOAD, 4'h1, 32'h0001_0000, 32'hFFFF_FFF9, 32'h0,
                           32'h0, ST_INTERP));
        plan.push_back(row(ROW_POINTS, 4'h0, 32'h0, 32'h0, 32'd2, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_EVAL_KNOWN, 4'h0, 32'h0, 32'h0, 32'hFFFE_0000,
                           32'd5, ST_BELOW));
        plan.push_back(row(ROW_EVAL_KNOWN, 4'h0, 32'h0, 32'h0, 32'h0002_0000,
                           32'hFFFF_FFF9, ST_ABOVE));
        plan.push_back(row(ROW_EVAL_KNOWN, 4'h0, 32'h0, 32'h0, 32'hFFFF_0000,
                           32'd5, ST_INTERP));
        plan.push_back(row(ROW_EVAL, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_LOAD, 4'h0, 32'h0, 32'd100, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_LOAD, 4'h1, 32'h0, 32'd200, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_EVAL_KNOWN, 4'h0, 32'h0, 32'h0, 32'h0, 32'd100, ST_INTERP));
        plan.push_back(row(ROW_EVAL_KNOWN, 4'h0, 32'h0, 32'h0, 32'h1, 32'd200, ST_ABOVE));
        plan.push_back(row(ROW_LOAD, 4'h0, 32'h100, 32'h10, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_LOAD, 4'h1, 32'hFFFF_FF00, 32'h20, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_LOAD, 4'h2, 32'h200, 32'h30, 32'h0, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_POINTS, 4'h0, 32'h0, 32'h0, 32'd3, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_EVAL, 4'h0, 32'h0, 32'h0, 32'h180, 32'h0, ST_INTERP));
        plan.push_back(row(ROW_EVAL_KNOWN, 4'h0, 32'h0, 32'h0, 32'h80, 32'h10, ST_BELOW));
        plan.push_back(row(ROW_EVAL_KNOWN, 4'h0, 32'h0, 32'h0, 32'h300, 32'h30, ST_ABOVE));

        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_POINTS: begin
                    settle();
                    write_points(plan[i].smp[4:0]);
                end
                ROW_LOAD: begin
                    push_request(OP_LOAD, plan[i].idx, plan[i].px, plan[i].py, plan[i].smp,
                                 1'b0, '0, ST_INTERP);
                end
                ROW_EVAL: begin
                    push_request(OP_EVAL, plan[i].idx, plan[i].px, plan[i].py, plan[i].smp,
                                 1'b0, '0, ST_INTERP);
                end
                default: begin
                    push_request(OP_EVAL, plan[i].idx, plan[i].px, plan[i].py, plan[i].smp,
                                 1'b1, plan[i].val, plan[i].st);
                end
            endcase
            sender_gap();
        end

        while (sent < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) pts = $urandom_range(0, 1);
            else if (pick < 16) pts = $urandom_range(MAX_POINTS + 1, 31);
            else if (pick < 30) pts = MAX_POINTS;
            else if (pick < 42) pts = 2;
            else pts = $urandom_range(3, MAX_POINTS - 1);
            used = (pts > MAX_POINTS) ? MAX_POINTS : pts;
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 15;
                default: stall_pct = 40;
            endcase

            settle();
            write_points(5'(pts));

            // Mostly ascending tables, wide or tightly spaced; a few are left unsorted.
            shape = $urandom_range(0, 9);
            for (a = 0; a < used; a++) cand[a] = longint'($signed($urandom));
            if (shape >= 5) begin
                key = longint'($signed($urandom)) >>> 4;
                span = $urandom_range(1, 1 << $urandom_range(0, 20));
                for (a = 0; a < used; a++) cand[a] = key + a * span;
            end else if (shape >= 1) begin
                for (a = 1; a < used; a++) begin
                    key = cand[a];
                    b = a - 1;
                    while (b >= 0 && cand[b] > key) begin
                        cand[b+1] = cand[b];
                        b--;
                    end
                    cand[b+1] = key;
                end
                if (used >= 2 && $urandom_range(0, 2) == 0) begin
                    cand[0] = -64'sd2147483648;
                    cand[used-1] = 64'sd2147483647;
                end
            end else if (used >= 2 && $urandom_range(0, 1) == 1) begin
                cand[1] = cand[0];
            end

            for (a = 0; a < used; a++) begin
                if ($urandom_range(0, 1) == 1) pyv = $urandom;
                else pyv = $signed($urandom) >>> $urandom_range(0, 24);
                push_request(OP_LOAD, a[3:0], cand[a][31:0], pyv, $urandom,
                             1'b0, '0, ST_INTERP);
                sender_gap();
            end

            evals = $urandom_range(15, 40);
            repeat (evals) begin
                if (sent >= ITEMS - 100) steady = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    push_request(OP_LOAD, 4'($urandom), $urandom, $urandom, $urandom,
                                 1'b0, '0, ST_INTERP);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 35 && used > 0) begin
                        k = $urandom_range(0, used - 1);
                        sv = bp_x[k];
                        sv = sv + (int'($urandom_range(0, 6)) - 3);
                    end else if (r < 70 && used > 1) begin
                        k = $urandom_range(0, used - 2);
                        span = longint'(bp_x[k+1]) - longint'(bp_x[k]);
                        sv = bp_x[k];
                        if (span > 0) begin
                            rnd = {$urandom, $urandom};
                            sv = sv + longint'(rnd % span);
                        end
                    end else if (r < 90) begin
                        sv = longint'($signed($urandom));
                    end else begin
                        sv = ($urandom_range(0, 1) == 1) ? -64'sd2147483648 : 64'sd2147483647;
                    end
                    push_request(OP_EVAL, 4'($urandom), $urandom, $urandom, sv[31:0],
                                 1'b0, '0, ST_INTERP);
                end
                sender_gap();
            end
        end

        settle();
        repeat (100) @(posedge aclk);
        if (err_count == 0 && mapped_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
